@@ design/txc_pkg.sv @@
package txc_pkg;

  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CURSOR_W = 11;
  localparam int IDX_W    = 11;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'h0a;
  localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'h20;
  localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'h31;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h30;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 8'd1;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] chr;
  } cell_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_e;

endpackage

@@ design/txc_if.sv @@
interface txc_in_if import txc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, cmd, char_code, cell_index, input ready);
  modport sink   (input valid, cmd, char_code, cell_index, output ready);
endinterface

interface txc_out_if import txc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   cell_char;
  logic [ATTR_W-1:0]   cell_attr;
  logic [CURSOR_W-1:0] cursor_now;
  logic                did_scroll;

  modport source (output valid, cell_char, cell_attr, cursor_now, did_scroll, input ready);
  modport sink   (input valid, cell_char, cell_attr, cursor_now, did_scroll, output ready);
endinterface

interface txc_cfg_if import txc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/text_console_writer.sv @@
// Text console with a ROWS x COLUMNS screen of 16-bit cells (attribute in the
// high byte, character in the low byte) held in one single-port-read,
// single-port-write synchronous memory, plus a linear cursor. After reset a
// clearing pass writes every cell to a space with attribute 0x30, during
// which no item is accepted (configuration writes are taken at any time). A
// put or a read does one memory access and then presents the result. A put
// that scrolls copies the screen up one row through the memory, one cell per
// cycle, then blanks the bottom row. The result register frees the input
// side: a new item is accepted while the last result still waits.
module text_console_writer import txc_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  txc_cfg_if.sink     cfg_i,
  txc_in_if.sink      in_i,
  txc_out_if.source   out_o
);

  localparam int CellCount    = ROWS * COLUMNS;
  localparam int LastRowStart = (ROWS - 1) * COLUMNS;
  localparam int AddrW        = $clog2(CellCount);
  localparam int RowW         = $clog2(ROWS);
  localparam int ColW         = $clog2(COLUMNS);

  state_e state_q, state_d;

  logic [AddrW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0]  lin_q, lin_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [ColW-1:0]   col_q, col_d;
  logic              pend_q, pend_d;
  logic [AddrW-1:0]  pend_addr_q;
  logic              rd_hit_q, rd_hit_d;
  logic              scroll_q, scroll_d;
  logic [ATTR_W-1:0] text_attr_q, blank_attr_q;

  logic              out_valid_q;
  cell_t             out_cell_q;
  logic [AddrW-1:0]  out_cursor_q;
  logic              out_scroll_q;

  cell_t             mem_q [CellCount];
  cell_t             rdata_q;

  logic              re;
  logic [AddrW-1:0]  raddr;
  logic              we;
  logic [AddrW-1:0]  waddr;
  cell_t             wdata;
  logic              in_ready;
  logic              load_out;
  logic              accept;
  logic              is_put, is_newline;
  logic              out_free;

  assign accept     = in_i.valid && in_ready;
  assign is_put     = (in_i.cmd == CMD_PUT);
  assign is_newline = (in_i.char_code == NEWLINE_CODE);
  assign out_free   = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (32'(cnt_q) == CellCount - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (is_put && scroll_d) state_d = ST_SCROLL;
          else                    state_d = ST_DONE;
        end
      end
      ST_SCROLL: begin
        if (32'(cnt_q) == LastRowStart - 1) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (!pend_q && 32'(cnt_q) == CellCount - 1) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory port control and handshake outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    re       = 1'b0;
    raddr    = AddrW'(in_i.cell_index);
    we       = 1'b0;
    waddr    = lin_q;
    wdata    = cell_t'{attr: text_attr_q, chr: in_i.char_code};
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = cell_t'{attr: BLANK_ATTR_RST, chr: SPACE_CODE};
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        re       = accept && !is_put;
        we       = accept && is_put && !is_newline;
      end
      ST_SCROLL: begin
        re    = 1'b1;
        raddr = AddrW'(32'(cnt_q) + COLUMNS);
        we    = pend_q;
        waddr = pend_addr_q;
        wdata = rdata_q;
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = pend_q ? pend_addr_q : cnt_q;
        wdata = pend_q ? rdata_q : cell_t'{attr: blank_attr_q, chr: SPACE_CODE};
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  // cursor and counter updates
  always_comb begin
    cnt_d    = cnt_q;
    lin_d    = lin_q;
    row_d    = row_q;
    col_d    = col_q;
    pend_d   = 1'b0;
    rd_hit_d = rd_hit_q;
    scroll_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = (32'(cnt_q) == CellCount - 1) ? '0 : cnt_q + 1'b1;
      end
      ST_IDLE: begin
        rd_hit_d = !is_put && (32'(in_i.cell_index) < CellCount);
        if (is_put) begin
          if (is_newline) begin
            scroll_d = (32'(row_q) == ROWS - 1);
            lin_d    = AddrW'(32'(lin_q) - 32'(col_q) + COLUMNS);
            row_d    = row_q + 1'b1;
            col_d    = '0;
          end else begin
            scroll_d = (32'(lin_q) == CellCount - 1);
            lin_d    = lin_q + 1'b1;
            if (32'(col_q) == COLUMNS - 1) begin
              col_d = '0;
              row_d = row_q + 1'b1;
            end else begin
              col_d = col_q + 1'b1;
            end
          end
          // a scroll always leaves the cursor at the start of the bottom row
          if (scroll_d) begin
            lin_d = AddrW'(LastRowStart);
            row_d = RowW'(ROWS - 1);
            col_d = '0;
          end
        end
        cnt_d = '0;
        if (!accept) begin
          lin_d    = lin_q;
          row_d    = row_q;
          col_d    = col_q;
          rd_hit_d = rd_hit_q;
          scroll_d = 1'b0;
        end
      end
      ST_SCROLL: begin
        pend_d   = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        scroll_d = 1'b1;
      end
      ST_FILL: begin
        scroll_d = 1'b1;
        if (!pend_q && 32'(cnt_q) != CellCount - 1) cnt_d = cnt_q + 1'b1;
      end
      ST_DONE: begin
        scroll_d = scroll_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      lin_q        <= '0;
      row_q        <= '0;
      col_q        <= '0;
      pend_q       <= 1'b0;
      rd_hit_q     <= 1'b0;
      scroll_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      text_attr_q  <= TEXT_ATTR_RST;
      blank_attr_q <= BLANK_ATTR_RST;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      lin_q    <= lin_d;
      row_q    <= row_d;
      col_q    <= col_d;
      pend_q   <= pend_d;
      rd_hit_q <= rd_hit_d;
      scroll_q <= scroll_d;
      if (load_out)          out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_TEXT_ATTR:  text_attr_q  <= ATTR_W'(cfg_i.data);
          REG_BLANK_ATTR: blank_attr_q <= ATTR_W'(cfg_i.data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCROLL) pend_addr_q <= cnt_q;
    if (load_out) begin
      out_cell_q   <= rd_hit_q ? rdata_q : '0;
      out_cursor_q <= lin_q;
      out_scroll_q <= scroll_q;
    end
  end

  // screen memory
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  assign cfg_i.ready      = 1'b1;
  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.cell_char  = out_cell_q.chr;
  assign out_o.cell_attr  = out_cell_q.attr;
  assign out_o.cursor_now = CURSOR_W'(out_cursor_q);
  assign out_o.did_scroll = out_scroll_q;

  // cursor stays on screen and agrees with its row and column
  a_cursor_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(lin_q) < CellCount) && (32'(lin_q) == 32'(row_q) * COLUMNS + 32'(col_q)))
    else $error("cursor out of range or inconsistent");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (32'(waddr) < CellCount))
    else $error("screen write beyond last cell");

  // row copy never writes the cell it reads in the same cycle
  a_scroll_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (waddr != raddr))
    else $error("read and write of the same cell");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result shown outside done state");

  a_scroll_lands_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && state_d == ST_DONE) |=> (32'(lin_q) == LastRowStart))
    else $error("cursor not on bottom row after scroll");

endmodule

@@ sim/tb_text_console_writer.sv @@
module tb_text_console_writer;
  import txc_pkg::*;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int IDX_SPAN   = 1 << IDX_W;

  typedef struct packed {
    logic              cmd;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } console_cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attr;
    logic [CURSOR_W-1:0] cursor_now;
    logic                did_scroll;
  } console_res_t;

  logic clk_i;
  logic rst_ni;

  txc_cfg_if cfg_if ();
  txc_in_if  in_if ();
  txc_out_if out_if ();

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // shadow of the console state
  cell_t             shadow_screen [CELL_COUNT];
  int                cursor_pos;
  logic [ATTR_W-1:0] text_attr;
  logic [ATTR_W-1:0] blank_attr;

  console_cmd_t stim_items[$];
  console_res_t expected_results[$];
  console_cmd_t offered;

  int src_idle_pct;
  int snk_idle_pct;
  bit hold_out;
  bit pressure_go;

  int errors;
  int n_items;
  int n_reads;
  int n_scrolls;
  int n_results;
  int n_reg_writes;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void console_reset();
    text_attr  = TEXT_ATTR_RST;
    blank_attr = BLANK_ATTR_RST;
    for (int i = 0; i < CELL_COUNT; i++) shadow_screen[i] = {BLANK_ATTR_RST, SPACE_CODE};
    cursor_pos = 0;
  endfunction

  function automatic void console_step(console_cmd_t it);
    console_res_t r;
    r = '0;
    n_items++;
    if (it.cmd == CMD_READ) begin
      n_reads++;
      if (it.cell_index < CELL_COUNT) begin
        r.cell_char = shadow_screen[it.cell_index].chr;
        r.cell_attr = shadow_screen[it.cell_index].attr;
      end
    end else begin
      if (it.char_code == NEWLINE_CODE) begin
        cursor_pos = (cursor_pos / COLUMNS + 1) * COLUMNS;
      end else begin
        if (cursor_pos < CELL_COUNT) shadow_screen[cursor_pos] = {text_attr, it.char_code};
        cursor_pos++;
      end
      // screen end reached: shift rows up and blank the bottom row
      if (cursor_pos >= CELL_COUNT) begin
        for (int i = 0; i < CELL_COUNT - COLUMNS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
          shadow_screen[i] = {blank_attr, SPACE_CODE};
        cursor_pos -= COLUMNS;
        r.did_scroll = 1'b1;
        n_scrolls++;
      end
    end
    r.cursor_now = CURSOR_W'(cursor_pos);
    expected_results.push_back(r);
  endfunction

  function automatic void queue_put(logic [CHAR_W-1:0] ch);
    console_cmd_t it;
    it.cmd        = CMD_PUT;
    it.char_code  = ch;
    it.cell_index = IDX_W'($urandom_range(IDX_SPAN - 1));
    stim_items.push_back(it);
  endfunction

  function automatic void queue_read(logic [IDX_W-1:0] idx);
    console_cmd_t it;
    it.cmd        = CMD_READ;
    it.char_code  = CHAR_W'($urandom_range(255));
    it.cell_index = idx;
    stim_items.push_back(it);
  endfunction

  function automatic logic [IDX_W-1:0] pick_cell();
    int sel;
    sel = $urandom_range(99);
    // most reads land on the lower rows where the text lands and scrolls through
    if (sel < 45) return IDX_W'($urandom_range(CELL_COUNT - 1, CELL_COUNT - 5 * COLUMNS));
    else if (sel < 85) return IDX_W'($urandom_range(CELL_COUNT - 1));
    else return IDX_W'($urandom_range(IDX_SPAN - 1));
  endfunction

  // mostly lines of text ended by a newline, with reads mixed in, plus some noise
  task automatic queue_traffic(input int count);
    int added;
    int len;
    console_cmd_t it;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 80) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(16);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 30) begin
            queue_read(pick_cell());
            added++;
          end
          queue_put(CHAR_W'($urandom_range(255)));
          added++;
        end
        queue_put(NEWLINE_CODE);
        added++;
      end else begin
        it = console_cmd_t'($urandom());
        stim_items.push_back(it);
        added++;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_TEXT_ATTR:  text_attr = val;
      REG_BLANK_ATTR: blank_attr = val;
      default: ;
    endcase
    n_reg_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (stim_items.size() != 0 || in_if.valid || expected_results.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) console_step(offered);
      if (!in_if.valid || in_if.ready) begin
        if (stim_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          offered = stim_items.pop_front();
          in_if.valid      <= 1'b1;
          in_if.cmd        <= offered.cmd;
          in_if.char_code  <= offered.char_code;
          in_if.cell_index <= offered.cell_index;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    console_res_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_if.cell_char !== want.cell_char) begin
            $error("cell_char: expected %0h, got %0h", want.cell_char, out_if.cell_char);
            errors++;
          end
          if (out_if.cell_attr !== want.cell_attr) begin
            $error("cell_attr: expected %0h, got %0h", want.cell_attr, out_if.cell_attr);
            errors++;
          end
          if (out_if.cursor_now !== want.cursor_now) begin
            $error("cursor_now: expected %0d, got %0d", want.cursor_now, out_if.cursor_now);
            errors++;
          end
          if (out_if.did_scroll !== want.did_scroll) begin
            $error("did_scroll: expected %0b, got %0b", want.did_scroll, out_if.did_scroll);
            errors++;
          end
        end
      end
      out_if.ready <= !hold_out && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // long receiver hold-off so the block fills up and stalls its input
  initial begin
    hold_out = 1'b0;
    wait (pressure_go);
    repeat (60) @(posedge clk_i);
    hold_out <= 1'b1;
    repeat (500) @(posedge clk_i);
    hold_out <= 1'b0;
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_PUT;
    in_if.char_code  = '0;
    in_if.cell_index = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    rst_ni           = 1'b0;
    src_idle_pct     = 17;
    snk_idle_pct     = 70;
    pressure_go      = 1'b0;
    errors           = 0;
    n_items          = 0;
    n_reads          = 0;
    n_scrolls        = 0;
    n_results        = 0;
    n_reg_writes     = 0;
    console_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: character extremes, reads in and out of range, newline
    queue_put(8'h41);
    queue_put(8'hff);
    queue_put(8'h00);
    queue_read(11'd0);
    queue_read(11'd1);
    queue_read(11'd2);
    queue_read(11'd3);
    queue_read(11'd1999);
    queue_read(11'd2000);
    queue_read(11'h7ff);
    queue_put(NEWLINE_CODE);
    queue_read(11'd80);
    wait_drained();

    // new attributes only apply to later writes and scrolls; bad indexes ignored
    write_reg(REG_TEXT_ATTR, 8'hff);
    write_reg(REG_BLANK_ATTR, 8'h00);
    write_reg(CFG_IDX_W'(2), 8'h5a);
    write_reg(CFG_IDX_W'(255), 8'ha5);
    queue_put(8'h7e);
    queue_put(NEWLINE_CODE);
    queue_read(11'd80);
    queue_read(11'd0);
    queue_read(11'd1);
    queue_read(11'd81);
    wait_drained();

    write_reg(REG_TEXT_ATTR, 8'h00);
    write_reg(REG_BLANK_ATTR, 8'hff);
    queue_traffic(230);
    wait_drained();

    src_idle_pct = 70;
    snk_idle_pct = 17;
    write_reg(REG_TEXT_ATTR, CFG_DATA_W'($urandom_range(255)));
    write_reg(REG_BLANK_ATTR, CFG_DATA_W'($urandom_range(255)));
    write_reg(CFG_IDX_W'($urandom_range(255, 2)), CFG_DATA_W'($urandom_range(255)));
    queue_traffic(230);
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(REG_TEXT_ATTR, TEXT_ATTR_RST);
    write_reg(REG_BLANK_ATTR, BLANK_ATTR_RST);
    queue_traffic(230);
    pressure_go = 1'b1;
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    $display("covered %0d transactions (%0d reads, %0d scrolls), %0d results checked",
             n_items, n_reads, n_scrolls, n_results);
    $display("register writes: %0d, idling on either side and a long output stall",
             n_reg_writes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
